// ===== rtl/core/bmmm_pkg.sv =====
// Shared types and constants for the mean/median/mode statistics buffer.
package bmmm_pkg;

  localparam int unsigned ActW   = 2;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 7;

  typedef enum logic [ActW-1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_STATS = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef struct packed {
    logic [ActW-1:0]         action;
    logic [IdxW-1:0]         index;
    logic signed [DataW-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    status;
    logic signed [DataW-1:0] read_value;
    logic signed [DataW-1:0] mean_value;
    logic signed [DataW-1:0] median_value;
    logic signed [DataW-1:0] mode_value;
  } rsp_t;

endpackage

// ===== rtl/core/bmmm_if.sv =====
// Valid/ready channel interfaces for requests, responses and configuration.
interface bmmm_req_if;
  logic          valid;
  logic          ready;
  bmmm_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bmmm_rsp_if;
  logic          valid;
  logic          ready;
  bmmm_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bmmm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bmmm_pkg::CountW-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/bmmm_div.sv =====
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
module bmmm_div #(
  parameter int unsigned DividendW = 44,
  parameter int unsigned DivisorW  = 13
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [DividendW-1:0]  dividend_i,
  input  logic [DivisorW-1:0]          divisor_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic signed [DividendW-1:0]  quotient_o
);
  localparam int unsigned CntW = $clog2(DividendW + 1);

  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW:0]    rem_q, rem_d;
  logic [DivisorW-1:0]  dvs_q, dvs_d;
  logic                 neg_q, neg_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic [DivisorW:0]    trial;
  logic [DividendW-1:0] mag;

  always_comb begin
    mag    = dividend_i[DividendW-1] ? DividendW'(-dividend_i) : dividend_i;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DivisorW-1:0], quo_q[DividendW-1]};
    if (start_i) begin
      quo_d  = mag;
      rem_d  = '0;
      dvs_d  = divisor_i;
      neg_d  = dividend_i[DividendW-1];
      cnt_d  = CntW'(DividendW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift one dividend bit into the remainder, subtract when it fits
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[DividendW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[DividendW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = neg_q ? DividendW'(-quo_q) : quo_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without busy");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !done_q) else $error("divider busy and done together");
  a_cnt_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q && !start_i |=> !busy_q) else $error("divider started spontaneously");
endmodule

// ===== rtl/core/buffer_mean_median_mode.sv =====
// Top level: Q16.16 value store with read, write and mean/median/mode query.
//
//  channel  dir  payload
//  req_if   in   action, index, value
//  rsp_if   out  status, read_value, mean_value, median_value, mode_value
//  cfg_if   in   count
//
// A write answers through the result register and a read through the memory read,
// data register and result register; a new request is taken only after the
// response beat is gone.
// A statistics query ranks every entry against all n entries with one comparator,
// one memory read per cycle, then divides the sum with the bit-serial divider.
// After reset a clearing pass zeroes every entry of the store; no request is
// taken meanwhile. A held response stalls the block until it is taken.
module buffer_mean_median_mode #(
  parameter int unsigned DEPTH = 64
) (
  input logic       clk_i,
  input logic       rst_ni,
  bmmm_req_if.sink  req_if,
  bmmm_rsp_if.source rsp_if,
  bmmm_cfg_if.sink  cfg_if
);
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW    = $clog2(DEPTH + 1);
  localparam int unsigned DW    = bmmm_pkg::DataW;
  localparam int unsigned SumW  = DW + NW;
  localparam int unsigned DivNW = (NW > bmmm_pkg::CountW) ? NW : bmmm_pkg::CountW;

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_RD    = 12'b000000000100,
    S_RDW   = 12'b000000001000,
    S_SUM   = 12'b000000010000,
    S_OUTER = 12'b000000100000,
    S_OWAIT = 12'b000001000000,
    S_INNER = 12'b000010000000,
    S_RANK  = 12'b000100000000,
    S_DIV   = 12'b001000000000,
    S_DWAIT = 12'b010000000000,
    S_RESP  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  logic signed [DW-1:0] mem [DEPTH];
  logic [AW-1:0]        raddr;
  logic signed [DW-1:0] rdata_q;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic signed [DW-1:0] wdata;

  logic [bmmm_pkg::CountW-1:0] count_q;
  logic [NW-1:0]        n;
  logic [NW:0]          i_q, i_d, j_q, j_d;
  logic signed [DW-1:0] x_q, x_d;
  logic [NW-1:0]        lt_q, lt_d, eq_q, eq_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic signed [DW-1:0] med_lo_q, med_lo_d, med_hi_q, med_hi_d, mode_q, mode_d;
  logic [NW-1:0]        best_q, best_d;
  logic                 first_q, first_d;
  bmmm_pkg::req_t       req_q, req_d;
  bmmm_pkg::rsp_t       rsp_q, rsp_d;
  logic                 rsp_v_q, rsp_v_d;
  logic signed [DW:0]   med_sum;
  logic [NW-1:0]        mid_hi, mid_lo;
  logic [NW:0]          lt_ext, le_ext;
  logic                 div_start, div_busy, div_done;
  logic signed [SumW-1:0] quo;

  assign n = (32'(count_q) > 32'(DEPTH)) ? NW'(DEPTH) : NW'(count_q);
  assign mid_hi = n >> 1;
  assign mid_lo = mid_hi - ((n[0]) ? NW'(0) : NW'(1));
  assign lt_ext = {1'b0, lt_q};
  assign le_ext = {1'b0, lt_q} + {1'b0, eq_q};

  assign req_if.ready = (state_q == S_IDLE) && !rsp_v_q;
  assign cfg_if.ready = 1'b1;

  bmmm_div #(.DividendW(SumW), .DivisorW(DivNW)) u_div (
    .clk_i, .rst_ni,
    .start_i   (div_start),
    .dividend_i(sum_q),
    .divisor_i (DivNW'(n)),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quotient_o(quo)
  );

  always_comb begin
    state_d  = state_q;
    i_d = i_q; j_d = j_q; x_d = x_q; lt_d = lt_q; eq_d = eq_q;
    sum_d = sum_q; med_lo_d = med_lo_q; med_hi_d = med_hi_q; mode_d = mode_q;
    best_d = best_q; first_d = first_q; req_d = req_q; rsp_d = rsp_q;
    rsp_v_d = rsp_v_q;
    raddr = AW'(0);
    we = 1'b0; waddr = AW'(i_q); wdata = '0;
    div_start = 1'b0;
    med_sum = (DW+1)'(med_lo_q) + (DW+1)'(med_hi_q);
    if (rsp_v_q && rsp_if.ready) rsp_v_d = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        i_d = i_q + 1'b1;
        if (i_q == (NW+1)'(DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_if.valid && req_if.ready) begin
          req_d = req_if.data;
          rsp_d = '0;
          unique case (bmmm_pkg::action_e'(req_if.data.action))
            bmmm_pkg::ACT_WRITE: begin
              if ((NW+bmmm_pkg::IdxW)'(req_if.data.index) < (NW+bmmm_pkg::IdxW)'(n)) begin
                we = 1'b1; waddr = AW'(req_if.data.index); wdata = req_if.data.value;
              end else rsp_d.status = 1'b1;
              state_d = S_RESP;
            end
            bmmm_pkg::ACT_READ: begin
              raddr = AW'(req_if.data.index);
              if ((NW+bmmm_pkg::IdxW)'(req_if.data.index) < (NW+bmmm_pkg::IdxW)'(n))
                state_d = S_RD;
              else begin
                rsp_d.status = 1'b1; state_d = S_RESP;
              end
            end
            bmmm_pkg::ACT_STATS: begin
              if (n == '0) state_d = S_RESP;
              else begin
                i_d = '0; j_d = '0; sum_d = '0; best_d = '0; first_d = 1'b1;
                state_d = S_OUTER;
              end
            end
            default: begin
              rsp_d.status = 1'b1; state_d = S_RESP;
            end
          endcase
        end
      end
      S_RD: begin
        // hold the read address so the data register keeps the entry
        raddr = AW'(req_q.index);
        state_d = S_RDW;
      end
      S_RDW: begin
        rsp_d.read_value = rdata_q; state_d = S_RESP;
      end
      S_OUTER: begin
        raddr = AW'(i_q);
        state_d = S_OWAIT;
      end
      S_OWAIT: begin
        raddr = AW'(i_q);
        state_d = S_SUM;
      end
      S_SUM: begin
        // latch pivot, accumulate sum, then sweep all entries
        x_d = rdata_q;
        sum_d = sum_q + SumW'(rdata_q);
        lt_d = '0; eq_d = '0; j_d = '0;
        raddr = AW'(0);
        state_d = S_INNER;
      end
      S_INNER: begin
        // rdata_q is entry j-1 when j>0 (the read data is registered)
        raddr = AW'(j_q);
        if (j_q != '0) begin
          if (rdata_q < x_q) lt_d = lt_q + 1'b1;
          else if (rdata_q == x_q) eq_d = eq_q + 1'b1;
        end
        j_d = j_q + 1'b1;
        if (j_q == (NW+1)'(n)) state_d = S_RANK;
      end
      S_RANK: begin
        // entry x occupies sorted positions lt .. lt+eq-1
        if (lt_ext <= (NW+1)'(mid_lo) && (NW+1)'(mid_lo) < le_ext) med_lo_d = x_q;
        if (lt_ext <= (NW+1)'(mid_hi) && (NW+1)'(mid_hi) < le_ext) med_hi_d = x_q;
        if (first_q || eq_q > best_q || (eq_q == best_q && x_q < mode_q)) begin
          mode_d = x_q; best_d = eq_q;
        end
        first_d = 1'b0;
        i_d = i_q + 1'b1;
        if (i_q == (NW+1)'(n - 1'b1)) state_d = S_DIV;
        else state_d = S_OUTER;
      end
      S_DIV: begin
        div_start = 1'b1; state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          rsp_d.mean_value   = DW'(quo);
          rsp_d.median_value = DW'(med_sum >>> 1);
          rsp_d.mode_value   = mode_q;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!rsp_v_q) begin
          rsp_v_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      i_q     <= '0;
      j_q     <= '0;
      rsp_v_q <= 1'b0;
      first_q <= 1'b1;
      count_q <= bmmm_pkg::CountW'(64);
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      rsp_v_q <= rsp_v_d;
      first_q <= first_d;
      if (cfg_if.valid && cfg_if.ready) count_q <= cfg_if.data;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; lt_q <= lt_d; eq_q <= eq_d; sum_q <= sum_d;
    med_lo_q <= med_lo_d; med_hi_q <= med_hi_d; mode_q <= mode_d;
    best_q <= best_d; req_q <= req_d; rsp_q <= rsp_d;
  end

  assign rsp_if.valid = rsp_v_q;
  assign rsp_if.data  = rsp_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_if.valid && req_if.ready |=> state_q != S_IDLE)
    else $error("request taken but sequencer stayed idle");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_v_q && !rsp_if.ready |=> rsp_v_q && $stable(rsp_q))
    else $error("response dropped while stalled");
  a_div_only_stats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> state_q == S_DIV) else $error("divider started outside query");
  a_div_busy_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> state_q == S_DWAIT) else $error("divider busy outside query");
endmodule
